// ----- rtl/klex_pkg.sv -----
`timescale 1ns / 1ps

package klex_pkg;

    // Longest word held in the buffer; longer words always become literals.
    localparam int MAX_WORD = 8;
    localparam int LEN_W    = $clog2(MAX_WORD + 1);
    localparam int IDX_W    = $clog2(MAX_WORD);

    // Output queue between the lexer core and the result channel.
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    localparam int KIND_W       = 6;
    localparam int NUM_KEYWORDS = 17;
    localparam int KW_MAX_LEN   = 8;

    // Token kind codes.
    localparam logic [KIND_W-1:0] KIND_LPAREN   = 6'd0;
    localparam logic [KIND_W-1:0] KIND_RPAREN   = 6'd1;
    localparam logic [KIND_W-1:0] KIND_LBRACE   = 6'd2;
    localparam logic [KIND_W-1:0] KIND_RBRACE   = 6'd3;
    localparam logic [KIND_W-1:0] KIND_SEMI     = 6'd4;
    localparam logic [KIND_W-1:0] KIND_ASSIGN   = 6'd5;
    localparam logic [KIND_W-1:0] KIND_GREATER  = 6'd6;
    localparam logic [KIND_W-1:0] KIND_LESS     = 6'd7;
    localparam logic [KIND_W-1:0] KIND_PLUS     = 6'd8;
    localparam logic [KIND_W-1:0] KIND_MINUS    = 6'd9;
    localparam logic [KIND_W-1:0] KIND_SLASH    = 6'd10;
    localparam logic [KIND_W-1:0] KIND_STAR     = 6'd11;
    localparam logic [KIND_W-1:0] KIND_AMP      = 6'd12;
    localparam logic [KIND_W-1:0] KIND_COLON    = 6'd13;
    localparam logic [KIND_W-1:0] KIND_DQUOTE   = 6'd14;
    localparam logic [KIND_W-1:0] KIND_SQUOTE   = 6'd15;
    localparam logic [KIND_W-1:0] KIND_KEYWORD0 = 6'd16;
    localparam logic [KIND_W-1:0] KIND_LITERAL  = 6'd33;
    localparam logic [KIND_W-1:0] KIND_END      = 6'd34;

    // Keywords in kind order; string literals are right-justified, so the
    // first character sits in the highest used byte.
    localparam logic [8*KW_MAX_LEN-1:0] KW_TEXT [NUM_KEYWORDS] = '{
        "int", "return", "var", "char", "float", "bool", "void", "if", "elif",
        "else", "do", "while", "fun", "switch", "case", "const", "continue"
    };

    localparam logic [3:0] KW_LEN [NUM_KEYWORDS] = '{
        4'd3, 4'd6, 4'd3, 4'd4, 4'd5, 4'd4, 4'd4, 4'd2, 4'd4,
        4'd4, 4'd2, 4'd5, 4'd3, 4'd6, 4'd4, 4'd5, 4'd8
    };

    typedef enum logic [1:0] {
        PHASE_IDLE    = 2'd0,
        PHASE_LETTERS = 2'd1,
        PHASE_DIGITS  = 2'd2
    } scan_phase_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              last;
    } token_t;

    typedef struct packed {
        logic              hit;
        logic [KIND_W-1:0] kind;
    } punct_t;

    function automatic logic is_letter(input logic [7:0] c);
        return c inside {[8'h61:8'h7a], [8'h41:8'h5a]};
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c inside {[8'h30:8'h39]};
    endfunction

    function automatic punct_t punct_kind(input logic [7:0] c);
        punct_t p;
        p.hit  = 1'b1;
        p.kind = KIND_PLUS;
        case (c)
            8'h28:   p.kind = KIND_LPAREN;
            8'h29:   p.kind = KIND_RPAREN;
            8'h7b:   p.kind = KIND_LBRACE;
            8'h7d:   p.kind = KIND_RBRACE;
            8'h3b:   p.kind = KIND_SEMI;
            8'h3d:   p.kind = KIND_ASSIGN;
            8'h3e:   p.kind = KIND_GREATER;
            8'h3c:   p.kind = KIND_LESS;
            8'h2b:   p.kind = KIND_PLUS;
            8'h25:   p.kind = KIND_PLUS;     // percent shares the plus kind
            8'h2d:   p.kind = KIND_MINUS;
            8'h2f:   p.kind = KIND_SLASH;
            8'h2a:   p.kind = KIND_STAR;
            8'h26:   p.kind = KIND_AMP;
            8'h3a:   p.kind = KIND_COLON;
            8'h22:   p.kind = KIND_DQUOTE;
            8'h27:   p.kind = KIND_SQUOTE;
            default: p.hit  = 1'b0;
        endcase
        return p;
    endfunction

endpackage

// ----- rtl/klex_in_if.sv -----
`timescale 1ns / 1ps

interface klex_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       end_of_text;

    modport source (output valid, output char_code, output end_of_text, input ready);
    modport sink   (input valid, input char_code, input end_of_text, output ready);
endinterface

// ----- rtl/klex_out_if.sv -----
`timescale 1ns / 1ps

interface klex_out_if;
    logic                        valid;
    logic                        ready;
    logic [klex_pkg::KIND_W-1:0] token_kind;
    logic                        last_of_run;

    modport source (output valid, output token_kind, output last_of_run, input ready);
    modport sink   (input valid, input token_kind, input last_of_run, output ready);
endinterface

// ----- rtl/keyword_token_lexer_top.sv -----
`timescale 1ns / 1ps

// Streaming keyword lexer. Source text enters on text_in, one byte per beat,
// with end_of_text marking the close of a text. Token kind codes leave on
// token_out, one token per beat; last_of_run flags the final token caused by
// one input beat (an input beat causes zero, one or two tokens).
//
// Every accepted byte updates the word buffer and scan phase in the same
// cycle and drops its tokens into a four-entry output queue, so the first
// token is visible in the cycle after the byte is accepted. A byte is taken on
// every cycle while the queue holds at most two tokens: one byte per cycle
// is sustained as long as bytes average no more than one token and the
// receiver takes a token each cycle; the single output port sets the limit,
// so a byte that yields two tokens needs an output beat for each token.
//
// When the receiver stalls, queued tokens hold and text_in.ready drops once
// the queue cannot take a two-token byte. Reset empties the queue and
// clears any word in progress; the word buffer itself needs no clearing.
module keyword_token_lexer_top (
    input  logic              clk,
    input  logic              rst_n,
    klex_in_if.sink           text_in,
    klex_out_if.source        token_out
);

    // Word state.
    klex_pkg::scan_phase_t     phase_reg, phase_next;
    logic [klex_pkg::LEN_W-1:0] word_length_reg, word_length_next;
    logic                      word_too_long_reg, word_too_long_next;
    logic [7:0]                word_chars_reg [klex_pkg::MAX_WORD];

    // Output queue.
    klex_pkg::token_t           fifo_reg [klex_pkg::FIFO_DEPTH];
    logic [klex_pkg::PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [klex_pkg::CNT_W-1:0] count_reg;

    logic                        in_fire, out_fire;
    logic                        letter, digit;
    klex_pkg::punct_t            punct;
    logic [klex_pkg::KIND_W-1:0] word_kind;
    logic [klex_pkg::KIND_W-1:0] other_kind;
    logic                        emit_word, emit_other;
    logic                        clear_word, start_fresh, push_char;
    logic [klex_pkg::LEN_W-1:0]  base_length;
    logic                        base_too_long;
    logic                        char_we;
    logic [klex_pkg::IDX_W-1:0]  char_idx;
    logic [1:0]                  push_count;
    klex_pkg::token_t            tok0, tok1;

    assign in_fire  = text_in.valid && text_in.ready;
    assign out_fire = token_out.valid && token_out.ready;

    assign letter = klex_pkg::is_letter(text_in.char_code);
    assign digit  = klex_pkg::is_digit(text_in.char_code);
    assign punct  = klex_pkg::punct_kind(text_in.char_code);

    // Parallel keyword match over the buffer. Only characters below the
    // keyword's length are compared, so unwritten entries never matter.
    always_comb
    begin
        logic hit;
        word_kind = klex_pkg::KIND_LITERAL;
        for (int k = 0; k < klex_pkg::NUM_KEYWORDS; k++)
        begin
            hit = (word_length_reg == klex_pkg::LEN_W'(klex_pkg::KW_LEN[k]));
            for (int i = 0; i < klex_pkg::KW_MAX_LEN; i++)
            begin
                if (i < int'(klex_pkg::KW_LEN[k]))
                begin
                    if (word_chars_reg[i] !=
                        klex_pkg::KW_TEXT[k][8*(int'(klex_pkg::KW_LEN[k]) - 1 - i) +: 8])
                    begin
                        hit = 1'b0;
                    end
                end
            end
            if (hit && !word_too_long_reg)
            begin
                word_kind = klex_pkg::KIND_KEYWORD0 + klex_pkg::KIND_W'(k);
            end
        end
    end

    // Scan phase sequencing and word buffer updates.
    always_comb
    begin
        phase_next         = phase_reg;
        word_length_next   = word_length_reg;
        word_too_long_next = word_too_long_reg;
        emit_word          = 1'b0;
        emit_other         = 1'b0;
        other_kind         = klex_pkg::KIND_END;
        clear_word         = 1'b0;
        start_fresh        = 1'b0;
        push_char          = 1'b0;
        char_we            = 1'b0;

        if (in_fire)
        begin
            if (text_in.end_of_text)
            begin
                emit_word  = (phase_reg != klex_pkg::PHASE_IDLE);
                emit_other = 1'b1;
                other_kind = klex_pkg::KIND_END;
                clear_word = 1'b1;
                phase_next = klex_pkg::PHASE_IDLE;
            end
            else
            begin
                case (phase_reg)
                    klex_pkg::PHASE_LETTERS:
                    begin
                        if (letter)
                        begin
                            push_char = 1'b1;
                        end
                        else if (digit)
                        begin
                            phase_next = klex_pkg::PHASE_DIGITS;
                            push_char  = 1'b1;
                        end
                        else
                        begin
                            emit_word   = 1'b1;
                            clear_word  = 1'b1;
                            start_fresh = 1'b1;
                        end
                    end
                    klex_pkg::PHASE_DIGITS:
                    begin
                        if (digit)
                        begin
                            push_char = 1'b1;
                        end
                        else
                        begin
                            emit_word   = 1'b1;
                            clear_word  = 1'b1;
                            start_fresh = 1'b1;
                        end
                    end
                    default:
                    begin
                        start_fresh = 1'b1;
                    end
                endcase

                if (start_fresh)
                begin
                    if (letter)
                    begin
                        phase_next = klex_pkg::PHASE_LETTERS;
                        push_char  = 1'b1;
                    end
                    else if (digit)
                    begin
                        phase_next = klex_pkg::PHASE_DIGITS;
                        push_char  = 1'b1;
                    end
                    else
                    begin
                        phase_next = klex_pkg::PHASE_IDLE;
                        emit_other = punct.hit;
                        other_kind = punct.kind;
                    end
                end
            end
        end

        // A word that just ended leaves an empty buffer for the new character.
        base_length   = clear_word ? '0 : word_length_reg;
        base_too_long = clear_word ? 1'b0 : word_too_long_reg;
        char_idx      = base_length[klex_pkg::IDX_W-1:0];

        if (clear_word)
        begin
            word_length_next   = '0;
            word_too_long_next = 1'b0;
        end
        if (push_char)
        begin
            if (base_length < klex_pkg::LEN_W'(klex_pkg::MAX_WORD))
            begin
                char_we            = 1'b1;
                word_length_next   = base_length + klex_pkg::LEN_W'(1);
                word_too_long_next = base_too_long;
            end
            else
            begin
                word_length_next   = base_length;
                word_too_long_next = 1'b1;
            end
        end
    end

    // Up to two tokens per byte: the ended word first, then the byte's own.
    always_comb
    begin
        push_count = {1'b0, emit_word} + {1'b0, emit_other};
        tok0.kind  = emit_word ? word_kind : other_kind;
        tok0.last  = !(emit_word && emit_other);
        tok1.kind  = other_kind;
        tok1.last  = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= klex_pkg::PHASE_IDLE;
            word_length_reg   <= '0;
            word_too_long_reg <= 1'b0;
            wr_ptr_reg        <= '0;
            rd_ptr_reg        <= '0;
            count_reg         <= '0;
        end
        else
        begin
            phase_reg         <= phase_next;
            word_length_reg   <= word_length_next;
            word_too_long_reg <= word_too_long_next;
            wr_ptr_reg        <= wr_ptr_reg + klex_pkg::PTR_W'(push_count);
            if (out_fire)
            begin
                rd_ptr_reg <= rd_ptr_reg + klex_pkg::PTR_W'(1);
            end
            count_reg <= count_reg + klex_pkg::CNT_W'(push_count)
                         - klex_pkg::CNT_W'(out_fire);
        end
    end

    always_ff @(posedge clk)
    begin
        if (char_we)
        begin
            word_chars_reg[char_idx] <= text_in.char_code;
        end
        if (push_count != 2'd0)
        begin
            fifo_reg[wr_ptr_reg] <= tok0;
        end
        if (push_count == 2'd2)
        begin
            fifo_reg[wr_ptr_reg + klex_pkg::PTR_W'(1)] <= tok1;
        end
    end

    // Room for a two-token byte is required before a byte is taken.
    assign text_in.ready         = (count_reg <= klex_pkg::CNT_W'(klex_pkg::FIFO_DEPTH - 2));
    assign token_out.valid       = (count_reg != '0);
    assign token_out.token_kind  = fifo_reg[rd_ptr_reg].kind;
    assign token_out.last_of_run = fifo_reg[rd_ptr_reg].last;

    // The queue never overflows.
    a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= klex_pkg::CNT_W'(klex_pkg::FIFO_DEPTH))
        else $error("output queue overflow");

    // An end of text always leaves the lexer with no word in progress.
    a_eot_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && text_in.end_of_text) |=>
            (phase_reg == klex_pkg::PHASE_IDLE && word_length_reg == '0
             && !word_too_long_reg))
        else $error("word state not cleared after end of text");

    // An overlong word only arises with a full buffer.
    a_too_long_full: assert property (@(posedge clk) disable iff (!rst_n)
        word_too_long_reg |->
            (word_length_reg == klex_pkg::LEN_W'(klex_pkg::MAX_WORD)))
        else $error("overlong flag set with a partial buffer");

    // With no word in progress the buffer is empty.
    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == klex_pkg::PHASE_IDLE) |-> (word_length_reg == '0))
        else $error("idle phase with characters buffered");

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps

// Checks the streaming keyword lexer against a predictor that lives in the
// testbench. Bytes go in on text_in, one per beat. Token kinds come out on
// token_out, one per beat.
//
// Every accepted input beat is run through the predictor. The predictor
// holds its own word buffer and scan phase. It queues the tokens that the
// beat must cause, and it marks the final token of each beat as the last of
// the run. Every accepted output beat is compared field by field with the
// oldest queued token.
module testbench;

    // A slow correct run is near 1000 beats, each with the longest gap and two
    // tokens that each wait out the longest stall, plus one long hold. The
    // limit allows several times the cycles that such a run takes.
    localparam int LIMIT_CYCLES = 400000;
    localparam int RANDOM_BEATS = 950;
    localparam int HOLD_CYCLES  = 150;

    // Expected token stream. It models the lexer state and keeps the tokens
    // that are still owed by the block.
    class lexer_token_book;
        string                 kw_names[klex_pkg::NUM_KEYWORDS] = '{
            "int", "return", "var", "char", "float", "bool", "void", "if", "elif",
            "else", "do", "while", "fun", "switch", "case", "const", "continue"
        };
        klex_pkg::token_t      pending_tokens[$];
        klex_pkg::scan_phase_t phase;
        logic [7:0]            word_buf[klex_pkg::MAX_WORD];
        int                    word_len;
        bit                    word_overflow;
        int                    failures;
        int                    tokens_seen;
        int                    keywords_seen;
        int                    literals_seen;
        int                    ends_seen;

        function new();
            phase         = klex_pkg::PHASE_IDLE;
            word_len      = 0;
            word_overflow = 0;
            failures      = 0;
            tokens_seen   = 0;
            keywords_seen = 0;
            literals_seen = 0;
            ends_seen     = 0;
        endfunction

        function bit is_alpha(logic [7:0] c);
            return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
        endfunction

        function bit is_num(logic [7:0] c);
            return c >= "0" && c <= "9";
        endfunction

        function void clear_word();
            phase         = klex_pkg::PHASE_IDLE;
            word_len      = 0;
            word_overflow = 0;
        endfunction

        // Characters that do not fit in the buffer are dropped. The word is
        // then flagged as a literal.
        function void push_char(logic [7:0] c);
            if (word_len < klex_pkg::MAX_WORD)
            begin
                word_buf[word_len] = c;
                word_len++;
            end
            else
                word_overflow = 1;
        endfunction

        function logic [klex_pkg::KIND_W-1:0] word_kind();
            bit same;
            if (word_overflow)
                return klex_pkg::KIND_LITERAL;
            for (int k = 0; k < klex_pkg::NUM_KEYWORDS; k++)
            begin
                if (kw_names[k].len() == word_len)
                begin
                    same = 1;
                    for (int i = 0; i < word_len; i++)
                        if (kw_names[k][i] != word_buf[i])
                            same = 0;
                    if (same)
                        return klex_pkg::KIND_KEYWORD0 + klex_pkg::KIND_W'(k);
                end
            end
            return klex_pkg::KIND_LITERAL;
        endfunction

        function int punct_code(logic [7:0] c);
            case (c)
                "(":     return klex_pkg::KIND_LPAREN;
                ")":     return klex_pkg::KIND_RPAREN;
                "{":     return klex_pkg::KIND_LBRACE;
                "}":     return klex_pkg::KIND_RBRACE;
                ";":     return klex_pkg::KIND_SEMI;
                "=":     return klex_pkg::KIND_ASSIGN;
                ">":     return klex_pkg::KIND_GREATER;
                "<":     return klex_pkg::KIND_LESS;
                "+":     return klex_pkg::KIND_PLUS;
                "%":     return klex_pkg::KIND_PLUS;
                "-":     return klex_pkg::KIND_MINUS;
                "/":     return klex_pkg::KIND_SLASH;
                "*":     return klex_pkg::KIND_STAR;
                "&":     return klex_pkg::KIND_AMP;
                ":":     return klex_pkg::KIND_COLON;
                "\"":    return klex_pkg::KIND_DQUOTE;
                "'":     return klex_pkg::KIND_SQUOTE;
                default: return -1;
            endcase
        endfunction

        function klex_pkg::token_t make_token(logic [klex_pkg::KIND_W-1:0] kind);
            klex_pkg::token_t t;
            t.kind = kind;
            t.last = 1'b0;
            return t;
        endfunction

        // Runs one accepted input beat through the lexer state and queues the
        // tokens that it causes.
        function void take_char(logic [7:0] c, logic eot);
            klex_pkg::token_t run[$];
            int               p;
            bit               absorbed;
            absorbed = 0;
            if (eot)
            begin
                if (phase != klex_pkg::PHASE_IDLE)
                    run = {run, make_token(word_kind())};
                clear_word();
                run = {run, make_token(klex_pkg::KIND_END)};
            end
            else
            begin
                if (phase == klex_pkg::PHASE_LETTERS && is_alpha(c))
                begin
                    push_char(c);
                    absorbed = 1;
                end
                else if (phase == klex_pkg::PHASE_LETTERS && is_num(c))
                begin
                    phase = klex_pkg::PHASE_DIGITS;
                    push_char(c);
                    absorbed = 1;
                end
                else if (phase == klex_pkg::PHASE_DIGITS && is_num(c))
                begin
                    push_char(c);
                    absorbed = 1;
                end
                else if (phase != klex_pkg::PHASE_IDLE)
                begin
                    run = {run, make_token(word_kind())};
                    clear_word();
                end

                // The character that ended the word is now handled on its own.
                if (!absorbed)
                begin
                    if (is_alpha(c))
                    begin
                        phase = klex_pkg::PHASE_LETTERS;
                        push_char(c);
                    end
                    else if (is_num(c))
                    begin
                        phase = klex_pkg::PHASE_DIGITS;
                        push_char(c);
                    end
                    else
                    begin
                        p = punct_code(c);
                        if (p >= 0)
                            run = {run, make_token(klex_pkg::KIND_W'(p))};
                    end
                end
            end
            if (run.size() > 0)
                run[run.size() - 1].last = 1'b1;
            foreach (run[i])
                pending_tokens = {pending_tokens, run[i]};
        endfunction

        function void match_token(logic [klex_pkg::KIND_W-1:0] kind, logic last);
            klex_pkg::token_t want;
            if (pending_tokens.size() == 0)
            begin
                $error("token with no expectation: token_kind %0d last_of_run %0d",
                       kind, last);
                failures++;
                return;
            end
            want = pending_tokens.pop_front();
            tokens_seen++;
            if (kind !== want.kind)
            begin
                $error("token_kind mismatch: expected %0d, actual %0d", want.kind, kind);
                failures++;
            end
            if (last !== want.last)
            begin
                $error("last_of_run mismatch: expected %0d, actual %0d", want.last, last);
                failures++;
            end
            if (want.kind == klex_pkg::KIND_END)
                ends_seen++;
            else if (want.kind == klex_pkg::KIND_LITERAL)
                literals_seen++;
            else if (want.kind >= klex_pkg::KIND_KEYWORD0)
                keywords_seen++;
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    klex_in_if  text_in_bus ();
    klex_out_if token_bus ();

    keyword_token_lexer_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .text_in   (text_in_bus),
        .token_out (token_bus)
    );

    lexer_token_book book = new();

    int cycle_count  = 0;
    int beats_sent   = 0;
    bit src_idle_on  = 0;
    bit sink_idle_on = 0;
    bit hold_request = 0;

    always #2 clk = ~clk;

    // The run stops at the cycle limit. This is the only timeout. Every
    // other wait goes through a handshake.
    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Output monitor. The testbench changes ready only at the falling edge,
    // and the block changes its registers only after the rising edge. So the
    // values read here are the ones that made the beat.
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && token_bus.valid === 1'b1 && token_bus.ready === 1'b1)
            book.match_token(token_bus.token_kind, token_bus.last_of_run);
    end

    // Gap lengths. Most are zero or short, and a few are long enough to drain
    // or fill the output queue.
    function automatic int idle_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 65)
            return 0;
        if (roll < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // The receiver side runs in a process of its own. It counts its own
    // stall cycles, so a long hold goes on while the sender keeps offering
    // beats. The block's queue then fills and text_in.ready drops.
    initial
    begin
        int stall_left;
        stall_left = 0;
        token_bus.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 0;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0)
            begin
                token_bus.ready = 1'b0;
                stall_left--;
            end
            else
            begin
                token_bus.ready = 1'b1;
                if (sink_idle_on)
                    stall_left = idle_gap();
            end
        end
    end

    // Offers one beat and holds it until it is accepted. The task is entered
    // at a falling edge and returns at the falling edge after acceptance.
    // So valid is either kept high for the next beat or lowered once for a
    // gap. It is never changed twice in one step.
    task automatic send_beat(input logic [7:0] c, input logic eot);
        int gap;
        gap = src_idle_on ? idle_gap() : 0;
        if (gap > 0)
        begin
            text_in_bus.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        text_in_bus.valid       = 1'b1;
        text_in_bus.char_code   = c;
        text_in_bus.end_of_text = eot;
        @(posedge clk);
        while (text_in_bus.ready !== 1'b1)
            @(posedge clk);
        book.take_char(c, eot);
        beats_sent++;
        @(negedge clk);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_beat(s[i], 1'b0);
    endtask

    // One piece of source text. Most pieces are well formed: keywords,
    // identifiers, numbers and punctuation, with separators between them so
    // that keywords are matched as keywords. The rest are noise bytes,
    // keywords with one letter in the wrong case, overlong words, and
    // end-of-text marks in the middle of a word.
    task automatic send_random_piece();
        logic [7:0] text[$];
        string      punct_set;
        int         roll;
        int         k;
        int         n;
        bit         is_word;
        punct_set = "(){};=><+-/*&:\"'%";
        roll = $urandom_range(0, 99);
        is_word = 0;
        if (roll < 30)
        begin
            k = $urandom_range(0, klex_pkg::NUM_KEYWORDS - 1);
            for (int i = 0; i < book.kw_names[k].len(); i++)
                text = {text, book.kw_names[k][i]};
            if ($urandom_range(0, 9) == 0)
            begin
                n = $urandom_range(0, text.size() - 1);
                text[n] = text[n] ^ 8'h20;
            end
            if ($urandom_range(0, 6) == 0)
                repeat ($urandom_range(1, 3)) text = {text, 8'($urandom_range("0", "9"))};
            is_word = 1;
        end
        else if (roll < 50)
        begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 6);
            repeat (n)
                text = {text, 8'($urandom_range("a", "z"))
                              ^ (($urandom_range(0, 3) == 0) ? 8'h20 : 8'h00)};
            if ($urandom_range(0, 4) == 0)
                repeat ($urandom_range(1, 4)) text = {text, 8'($urandom_range("0", "9"))};
            is_word = 1;
        end
        else if (roll < 60)
        begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 12) : $urandom_range(1, 4);
            repeat (n) text = {text, 8'($urandom_range("0", "9"))};
            is_word = 1;
        end
        else if (roll < 80)
            text = {text, punct_set[$urandom_range(0, punct_set.len() - 1)]};
        else if (roll < 95)
        begin
            if ($urandom_range(0, 9) < 7)
                text = {text, (($urandom_range(0, 1) == 0) ? 8'h20 : 8'h0a)};
            else
                text = {text, 8'($urandom_range(0, 255))};
        end
        else
        begin
            send_beat(8'($urandom_range(0, 255)), 1'b1);
            return;
        end

        // Most words are closed by a space or a punctuation mark. The others
        // run straight into the next piece.
        if (is_word && $urandom_range(0, 9) < 7)
            text = {text, (($urandom_range(0, 1) == 0) ? 8'h20
                           : punct_set[$urandom_range(0, punct_set.len() - 1)])};
        foreach (text[i])
            send_beat(text[i], 1'b0);
    endtask

    initial
    begin
        rst_n                   = 1'b0;
        text_in_bus.valid       = 1'b0;
        text_in_bus.char_code   = 8'h00;
        text_in_bus.end_of_text = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed opening, with random gaps on both sides.
        src_idle_on  = 1;
        sink_idle_on = 1;
        // The zero byte and the top byte give no token.
        send_beat(8'h00, 1'b0);
        send_beat(8'hFF, 1'b0);
        // A keyword ended by percent gives the keyword and then plus, both
        // from one beat.
        send_text("int%");
        // A letter after digits ends the word and starts a new one.
        send_text("a12b");
        // A digit after a letter joins the word. End of text then flushes it and gives
        // the end token from the same beat.
        send_text("7");
        send_beat(8'hFF, 1'b1);
        // End of text with no word pending gives only the end token.
        send_beat(8'hFF, 1'b1);
        // A longest keyword with one letter too many, closed by a single
        // quote. It is an overlong word, so it gives a literal.
        send_text("continuex'");

        // Random text in four idling patterns: free running, gaps on both
        // sides, a long receiver hold against a sender with no gaps, and
        // gaps on the sender only.
        for (int ph = 0; ph < 4; ph++)
        begin
            src_idle_on  = (ph == 1) || (ph == 3);
            sink_idle_on = (ph == 1) || (ph == 2);
            if (ph == 2)
                hold_request = 1;
            while (beats_sent < (ph + 1) * RANDOM_BEATS / 4)
                send_random_piece();
        end
        send_beat(8'h00, 1'b1);
        text_in_bus.valid = 1'b0;

        while (book.pending_tokens.size() > 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Sent %0d text beats and checked %0d tokens",
                 beats_sent, book.tokens_seen);
        $display("(%0d keywords, %0d literals, %0d ends).",
                 book.keywords_seen, book.literals_seen, book.ends_seen);
        $display("Idling ran free, with gaps on each side, and with a long hold on the receiver.");
        if (book.failures == 0 && book.pending_tokens.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
